// File: rtl/voq_pkg.sv
`default_nettype none
package voq_pkg;

  localparam int POS_W  = 32;
  localparam int REL_W  = POS_W + 1;
  localparam int HALF_W = 16;
  localparam int PROD_W = REL_W + HALF_W + 1;
  localparam int SUM_W  = PROD_W + HALF_W;
  localparam int DIM_W  = 13;
  localparam int AREA_W = 2 * DIM_W;
  localparam int VOL_W  = AREA_W + DIM_W;
  localparam int LIN_W  = VOL_W + 1;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_INV_SCALE,
    REG_DIM_X,
    REG_DIM_Y,
    REG_DIM_Z
  } cfg_reg_t;

  typedef struct packed {
    logic                    kind;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic [15:0]             voxel_index;
    logic [7:0]              voxel_value;
  } voq_in_t;

  typedef struct packed {
    logic occupied;
    logic outside;
  } voq_out_t;

  // Load enables of the three front stages of an axis pipe.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wbit;
  } mem_req_t;

endpackage
`default_nettype wire

// File: rtl/voxel_occupancy_query_unit.sv
`default_nettype none
// Voxel occupancy lookup. Write transactions store one occupancy bit per
// voxel; query transactions map a Q16.16 point to a cell and return one
// result each. The unit takes one transaction per cycle while in_stall is
// low. A query passes three stages per axis (offset,
// split multiply, floor and bounds), one for the linear-index products, and
// the single-port store read, whose data register is the output stage.
// Writes travel the same pipe and update the store in that last stage, so
// queries and writes take effect strictly in order. After reset the store is
// cleared one entry per cycle, which holds in_stall high until every entry
// is cleared; configuration writes are taken throughout.
module voxel_occupancy_query_unit #(
  parameter int VOXEL_COUNT = 65536,
  parameter int DIM_MAX     = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  voq_pkg::voq_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output voq_pkg::voq_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [voq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [voq_pkg::CFG_W-1:0]       cfg_data
);
  import voq_pkg::*;

  localparam int AW = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;

  logic signed [POS_W-1:0] origin_x;
  logic signed [POS_W-1:0] origin_y;
  logic signed [POS_W-1:0] origin_z;
  logic [POS_W-1:0]        inv_voxel_scale;
  logic [DIM_W-1:0]        dim_x;
  logic [DIM_W-1:0]        dim_y;
  logic [DIM_W-1:0]        dim_z;
  logic [DIM_W-1:0]        dim_sat;
  logic [AREA_W-1:0]       area;
  logic                    no_map;

  logic v1, v2, v3, v4, v5;
  logic ready1, ready2, ready3, ready4, ready5;
  logic kind1, kind2, kind3, kind4;
  logic wbit1, wbit2, wbit3, wbit4;
  logic [15:0] widx1, widx2, widx3, widx4;

  stage_en_t        axis_en;
  logic [DIM_W-1:0] cx, cy, cz;
  logic             oob_x, oob_y, oob_z;

  logic [DIM_W-1:0]  x4;
  logic [AREA_W-1:0] m1;
  logic [VOL_W-1:0]  m2;
  logic              out4;
  logic              out5;

  logic [LIN_W-1:0] lin;
  logic [LIN_W-1:0] addr_full;
  logic             in_store;
  mem_req_t         req;
  logic             rdata;
  logic             store_busy;

  // Configuration registers; dimensions saturate at DIM_MAX.
  assign dim_sat = (17'(cfg_data[DIM_W-1:0]) > 17'(DIM_MAX)) ? DIM_W'(DIM_MAX)
                                                           : cfg_data[DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      origin_y        <= '0;
      origin_z        <= '0;
      inv_voxel_scale <= '0;
      dim_x           <= '0;
      dim_y           <= '0;
      dim_z           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:  origin_x        <= $signed(cfg_data);
        REG_ORIGIN_Y:  origin_y        <= $signed(cfg_data);
        REG_ORIGIN_Z:  origin_z        <= $signed(cfg_data);
        REG_INV_SCALE: inv_voxel_scale <= cfg_data;
        REG_DIM_X:     dim_x           <= dim_sat;
        REG_DIM_Y:     dim_y           <= dim_sat;
        REG_DIM_Z:     dim_z           <= dim_sat;
        default: ;
      endcase
    end
  end

  // The plane size is registered from the dimension registers and follows them in the next cycle.
  always_ff @(posedge clk) begin
    area <= AREA_W'(dim_x) * AREA_W'(dim_y);
  end

  assign no_map = (inv_voxel_scale == '0) || (dim_x == '0) ||
                  (dim_y == '0) || (dim_z == '0);

  // Each stage takes a new transaction when it is empty or its own moves on.
  assign ready5 = !v5 || !out_stall;
  assign ready4 = !v4 || ready5;
  assign ready3 = !v3 || ready4;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  assign in_stall = store_busy || !ready1;

  assign axis_en.s1 = ready1;
  assign axis_en.s2 = ready2;
  assign axis_en.s3 = ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid && !in_stall;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
      if (ready5) v5 <= v4 && (kind4 == KIND_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      kind1 <= in_data.kind;
      widx1 <= in_data.voxel_index;
      wbit1 <= (in_data.voxel_value != '0);
    end
    if (ready2) begin
      kind2 <= kind1;
      widx2 <= widx1;
      wbit2 <= wbit1;
    end
    if (ready3) begin
      kind3 <= kind2;
      widx3 <= widx2;
      wbit3 <= wbit2;
    end
    if (ready4) begin
      kind4 <= kind3;
      widx4 <= widx3;
      wbit4 <= wbit3;
      x4    <= cx;
      m1    <= AREA_W'(dim_x) * AREA_W'(cy);
      m2    <= VOL_W'(area) * VOL_W'(cz);
      out4  <= no_map || oob_x || oob_y || oob_z;
    end
    if (ready5) begin
      out5 <= out4 || !in_store;
    end
  end

  voq_axis u_axis_x (
    .clk        (clk),
    .en         (axis_en),
    .pos        (in_data.x_pos),
    .org        (origin_x),
    .scale      (inv_voxel_scale),
    .dim        (dim_x),
    .cell_index (cx),
    .oob        (oob_x)
  );

  voq_axis u_axis_y (
    .clk        (clk),
    .en         (axis_en),
    .pos        (in_data.y_pos),
    .org        (origin_y),
    .scale      (inv_voxel_scale),
    .dim        (dim_y),
    .cell_index (cy),
    .oob        (oob_y)
  );

  voq_axis u_axis_z (
    .clk        (clk),
    .en         (axis_en),
    .pos        (in_data.z_pos),
    .org        (origin_z),
    .scale      (inv_voxel_scale),
    .dim        (dim_z),
    .cell_index (cz),
    .oob        (oob_z)
  );

  assign lin       = LIN_W'(x4) + LIN_W'(m1) + LIN_W'(m2);
  assign addr_full = (kind4 == KIND_QUERY) ? lin : LIN_W'(widx4);
  assign in_store  = addr_full < LIN_W'(VOXEL_COUNT);

  assign req.rd   = ready5 && v4 && (kind4 == KIND_QUERY);
  assign req.wr   = ready5 && v4 && (kind4 == KIND_WRITE) && in_store;
  assign req.wbit = wbit4;

  voq_store #(
    .DEPTH (VOXEL_COUNT),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .addr  (addr_full[AW-1:0]),
    .rdata (rdata),
    .busy  (store_busy)
  );

  assign out_valid         = v5;
  assign out_data.occupied = rdata && !out5;
  assign out_data.outside  = out5;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) store_busy |-> in_stall
  ) else $error("transaction accepted during the store clearing pass");

  a_single_port: assert property (
    @(posedge clk) disable iff (rst) !(req.rd && req.wr)
  ) else $error("store read and write issued together");

  a_outside_is_free: assert property (
    @(posedge clk) disable iff (rst) out_valid |-> !(out_data.occupied && out_data.outside)
  ) else $error("outside result reported as occupied");

  a_blocked_stage_holds: assert property (
    @(posedge clk) disable iff (rst) (v4 && !ready5) |=> v4
  ) else $error("blocked transaction lost from the index stage");

endmodule
`default_nettype wire

// File: rtl/voq_axis.sv
`default_nettype none
module voq_axis (
  input  logic                              clk,
  input  voq_pkg::stage_en_t                en,
  input  logic signed [voq_pkg::POS_W-1:0]  pos,
  input  logic signed [voq_pkg::POS_W-1:0]  org,
  input  logic [voq_pkg::POS_W-1:0]         scale,
  input  logic [voq_pkg::DIM_W-1:0]         dim,
  output logic [voq_pkg::DIM_W-1:0]         cell_index,
  output logic                              oob
);
  import voq_pkg::*;

  logic signed [REL_W-1:0]  rel;
  logic signed [REL_W-1:0]  rel_next;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_hi_next;
  logic signed [PROD_W-1:0] prod_lo_next;
  logic [SUM_W-1:0]         sum;
  logic                     in_range;

  assign rel_next = $signed({pos[POS_W-1], pos}) - $signed({org[POS_W-1], org});

  // The scale is split into halves so that each product stays narrow.
  assign prod_hi_next = PROD_W'(rel) * PROD_W'($signed({1'b0, scale[POS_W-1:HALF_W]}));
  assign prod_lo_next = PROD_W'(rel) * PROD_W'($signed({1'b0, scale[HALF_W-1:0]}));

  // Exact product rel * scale; its top part above bit 31 is the floored cell.
  assign sum = {prod_hi, {HALF_W{1'b0}}} + {{HALF_W{prod_lo[PROD_W-1]}}, prod_lo};

  assign in_range = (sum[SUM_W-1:2*HALF_W+DIM_W] == '0) &&
                    (sum[2*HALF_W+DIM_W-1:2*HALF_W] < dim);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      rel <= rel_next;
    end
    if (en.s2) begin
      prod_hi <= prod_hi_next;
      prod_lo <= prod_lo_next;
    end
    if (en.s3) begin
      cell_index <= sum[2*HALF_W+DIM_W-1:2*HALF_W];
      oob        <= !in_range;
    end
  end

endmodule
`default_nettype wire

// File: rtl/voq_store.sv
`default_nettype none
module voq_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  voq_pkg::mem_req_t req,
  input  logic [AW-1:0]     addr,
  output logic              rdata,
  output logic              busy
);
  import voq_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // After reset every entry is swept to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == LAST) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (req.wr) begin
      mem[addr] <= req.wbit;
    end
    if (req.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire
